[hw/rtl/hfr_pkg.sv]
// Shared constants, types and the FCS-16 byte update for the HDLC frame receiver.
package hfr_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    localparam int          LEN_W     = 13;
    localparam int          PLEN_W    = 12;
    localparam logic [12:0] LEN_MIN   = 13'd2;
    localparam logic [12:0] LEN_MAX   = 13'd4096;

    localparam logic        KIND_DATA = 1'b0;
    localparam logic        KIND_END  = 1'b1;

    localparam logic [1:0]  ST_GOOD     = 2'd0;
    localparam logic [1:0]  ST_BAD_FCS  = 2'd1;
    localparam logic [1:0]  ST_SHORT    = 2'd2;
    localparam logic [1:0]  ST_OVERFLOW = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              out_kind;
        logic [7:0]        data_byte;
        logic [1:0]        frame_status;
        logic [PLEN_W-1:0] payload_len;
        logic              last;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_flags;

    // reflected CRC-16/X.25, one byte, bit at a time
    function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] c;
        c = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/hfr_if.sv]
// Valid/ready channel interfaces for received bytes and receiver results.
interface hfr_in_if;
    import hfr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface hfr_out_if;
    import hfr_pkg::*;
    logic              valid;
    logic              ready;
    logic              out_kind;
    logic [7:0]        data_byte;
    logic [1:0]        frame_status;
    logic [PLEN_W-1:0] payload_len;
    logic              last;
    modport source(output valid, output out_kind, output data_byte, output frame_status,
                   output payload_len, output last, input ready);
    modport sink(input valid, input out_kind, input data_byte, input frame_status,
                 input payload_len, input last, output ready);
endinterface

[hw/rtl/hfr_front.sv]
// Front end: frame state machine, unescape, FCS check, two-byte hold and result build.
module hfr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [12:0]           i_cfg_wr_data,
    hfr_in_if.sink                i_in,
    input  hfr_pkg::t_queue_flags i_qflags,
    output logic                  o_push,
    output hfr_pkg::t_result      o_result
);
    import hfr_pkg::*;

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_SYNC = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;
    localparam logic [1:0] MODE_ESC  = 2'd3;

    logic [1:0]       r_mode, n_mode;
    logic [15:0]      r_fcs, n_fcs;
    logic [LEN_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_limit;
    logic [7:0]       r_hold0, n_hold0;
    logic [7:0]       r_hold1, n_hold1;

    logic              accept;
    logic              do_store;
    logic [7:0]        store_byte;
    logic [PLEN_W-1:0] emitted;
    logic [15:0]       fcs_next;

    assign i_in.ready = !i_qflags.full;
    assign accept     = i_in.valid && i_in.ready;
    assign emitted    = (r_count >= LEN_MIN) ? PLEN_W'(r_count - LEN_MIN) : '0;
    assign store_byte = (r_mode == MODE_ESC) ? (i_in.rx_byte ^ ESC_XOR) : i_in.rx_byte;
    assign fcs_next   = fcs_step(r_fcs, store_byte);

    always_comb begin
        n_mode   = r_mode;
        n_fcs    = r_fcs;
        n_count  = r_count;
        n_hold0  = r_hold0;
        n_hold1  = r_hold1;
        do_store = 1'b0;
        o_push   = 1'b0;
        o_result = '0;
        if (accept) begin
            unique case (r_mode)
                MODE_HUNT: begin
                    if (i_in.rx_byte == FLAG_BYTE) begin
                        n_mode  = MODE_SYNC;
                        n_fcs   = FCS_INIT;
                        n_count = '0;
                    end
                end
                MODE_SYNC: begin
                    if (i_in.rx_byte == ESC_BYTE) begin
                        n_mode = MODE_ESC;
                    end else if (i_in.rx_byte != FLAG_BYTE) begin
                        do_store = 1'b1;
                    end
                end
                MODE_DATA: begin
                    if (i_in.rx_byte == ESC_BYTE) begin
                        n_mode = MODE_ESC;
                    end else if (i_in.rx_byte == FLAG_BYTE) begin
                        // close the frame and open the next one on the same flag
                        o_push               = 1'b1;
                        o_result.out_kind    = KIND_END;
                        o_result.last        = 1'b1;
                        o_result.payload_len = emitted;
                        if (r_count < LEN_MIN) begin
                            o_result.frame_status = ST_SHORT;
                        end else if (r_fcs != FCS_GOOD) begin
                            o_result.frame_status = ST_BAD_FCS;
                        end else begin
                            o_result.frame_status = ST_GOOD;
                        end
                        n_mode  = MODE_SYNC;
                        n_fcs   = FCS_INIT;
                        n_count = '0;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                MODE_ESC: begin
                    do_store = 1'b1;
                end
                default: begin
                    n_mode = MODE_HUNT;
                end
            endcase

            if (do_store) begin
                if (r_count >= r_limit) begin
                    // drop the byte, report overflow and hunt again
                    o_push                = 1'b1;
                    o_result.out_kind     = KIND_END;
                    o_result.last         = 1'b1;
                    o_result.frame_status = ST_OVERFLOW;
                    o_result.payload_len  = emitted;
                    n_mode                = MODE_HUNT;
                    n_fcs                 = FCS_INIT;
                    n_count               = '0;
                end else begin
                    if (r_count >= LEN_MIN) begin
                        o_push             = 1'b1;
                        o_result.out_kind  = KIND_DATA;
                        o_result.data_byte = r_hold0;
                    end
                    n_hold0 = r_hold1;
                    n_hold1 = store_byte;
                    n_count = r_count + LEN_W'(1);
                    n_fcs   = fcs_next;
                    n_mode  = MODE_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_fcs   <= FCS_INIT;
            r_count <= '0;
            r_limit <= LEN_MAX;
        end else begin
            r_mode  <= n_mode;
            r_fcs   <= n_fcs;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                // clamp the length limit once, on write
                if (i_cfg_wr_data < LEN_MIN) begin
                    r_limit <= LEN_MIN;
                end else if (i_cfg_wr_data > LEN_MAX) begin
                    r_limit <= LEN_MAX;
                end else begin
                    r_limit <= i_cfg_wr_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold0 <= n_hold0;
        r_hold1 <= n_hold1;
    end

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HUNT) |-> (r_count == '0 && r_fcs == FCS_INIT))
        else $error("hunting with stale frame state");

    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_limit >= LEN_MIN) && (r_limit <= LEN_MAX))
        else $error("length limit outside clamp range");

endmodule

[hw/rtl/hfr_queue.sv]
// Short result queue between the front end and the output stage.
module hfr_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hfr_pkg::t_result      i_data,
    input  logic                  i_pop,
    output hfr_pkg::t_result      o_data,
    output hfr_pkg::t_queue_flags o_flags
);
    import hfr_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;

    assign o_data        = r_mem[r_rd_ptr];
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QUEUE_CW'(1);
            2'b01:   n_count = r_count - QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_flags.full)
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_flags.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count past depth");

endmodule

[hw/rtl/hfr_back.sv]
// Output stage: pulls results from the queue into a registered valid/ready source.
module hfr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hfr_pkg::t_result      i_data,
    input  hfr_pkg::t_queue_flags i_qflags,
    output logic                  o_pop,
    hfr_out_if.source             o_out
);
    import hfr_pkg::*;

    logic    r_valid;
    t_result r_data;
    logic    load;

    // refill when empty or the held result is being taken
    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && !i_qflags.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qflags.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_kind     = r_data.out_kind;
    assign o_out.data_byte    = r_data.data_byte;
    assign o_out.frame_status = r_data.frame_status;
    assign o_out.payload_len  = r_data.payload_len;
    assign o_out.last         = r_data.last;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped result not presented");

endmodule

[hw/rtl/hdlc_frame_receiver_unit.sv]
// Top level of the HDLC frame receiver: front end, result queue and output stage.
//
// Channels: i_in_ch takes one raw line byte per transfer (valid/ready). o_out_ch
// gives at most one result per byte: a payload byte (out_kind 0) or an end of
// frame report (out_kind 1, last 1) with frame_status and payload_len.
// i_cfg_wr_en / i_cfg_wr_data write max_len; values below 2 or above 4096 are
// clamped on write. Write it only while the receiver is idle.
// Throughput: one byte per cycle while the queue is not full. Unescape, FCS
// update and frame state all resolve in the front end within the accepting
// cycle. A result is written into the queue at the edge that takes its byte,
// then loaded into the output register.
// Reset (i_rst_n low, synchronous): hunting for a flag, FCS 0xFFFF, count 0,
// max_len 4096, queue and output register empty.
// Stall: if the sink holds ready low the output register keeps its result and
// the two-entry queue absorbs further results; i_in_ch.ready drops only while
// the queue is full.
module hdlc_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    hfr_in_if.sink      i_in_ch,
    hfr_out_if.source   o_out_ch
);
    import hfr_pkg::*;

    logic         push;
    logic         pop;
    t_result      front_result;
    t_result      head_result;
    t_queue_flags qflags;

    hfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in_ch),
        .i_qflags      (qflags),
        .o_push        (push),
        .o_result      (front_result)
    );

    hfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_result),
        .i_pop   (pop),
        .o_data  (head_result),
        .o_flags (qflags)
    );

    hfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (head_result),
        .i_qflags (qflags),
        .o_pop    (pop),
        .o_out    (o_out_ch)
    );

endmodule
